[hdl/tsg_pkg.sv]
// Package for the three-channel square tone generator.
// Holds shared widths, channel volumes, default parameters and the
// request and response structs of the shared subtract unit.
package tsg_pkg;

	localparam int unsigned NUM_CHAN    = 3;
	localparam int unsigned PER_W       = 6;
	localparam int unsigned CNT_W       = 9;
	localparam int unsigned ACC_W       = 10;
	localparam int unsigned TICK_W      = 8;
	localparam int unsigned SAMPLE_W    = 16;
	localparam int unsigned LVL_A_W     = 13;
	localparam int unsigned LVL_B_W     = 14;
	localparam int unsigned LVL_C_W     = 15;
	localparam int unsigned IN_DATA_W   = 24;
	localparam int unsigned OUT_DATA_W  = 64;

	localparam int unsigned MAX_TICKS_DEF = 255;

	localparam int VOL_A = 3840;
	localparam int VOL_B = 5120;
	localparam int VOL_C = 8192;

	localparam logic [1:0] ADDR_CTRL = 2'd3;
	localparam logic       CMD_TICK  = 1'b0;
	localparam logic       CMD_WRITE = 1'b1;

	localparam int unsigned CTRL_MIX_BIT = 0;
	localparam int unsigned CTRL_EN_BIT  = 1;

	typedef struct packed {
		logic             start;
		logic [ACC_W-1:0] rem_init;
		logic [PER_W-1:0] per;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [ACC_W-1:0] rem;
		logic             par;
	} div_rsp_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic signed [LVL_A_W-1:0]  level_a;
		logic signed [LVL_B_W-1:0]  level_b;
		logic signed [LVL_C_W-1:0]  level_c;
	} levels_t;

endpackage

[hdl/three_square_tone_generator.sv]
// Top level of the three-channel square tone generator.
// Holds the register file, the channel sequencer and the output register.
// Depends on tsg_pkg, tsg_divider and tsg_mixer.
//
//   channel | direction | signals                          | carries
//   s       | in        | s_tvalid s_tready s_tdata s_tuser | register write or tick item
//   m       | out       | m_tvalid m_tready m_tdata         | sample and three levels
//
// A register write gives no result.
// With the enable bit set, a tick item visits the three channels in turn on
// one shared subtractor, which subtracts the channel's period repeatedly; a
// channel with a zero period is skipped. Else the item goes straight to output.
// Reset clears all periods, counters, phases and the control byte.
// A result waiting on m holds back the next tick item at its last step only.
module three_square_tone_generator
	import tsg_pkg::*;
#(
	parameter int unsigned MAX_TICKS = MAX_TICKS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // reg_addr[1:0], write_data[9:2], ticks[17:10]
	input  logic                  s_tuser,   // cmd
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata    // sample, level_a, level_b, level_c
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CHAN = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t              state_q;
	logic [1:0]          ch_q;
	logic [TICK_W-1:0]   ticks_q;
	logic [PER_W-1:0]    period_q [NUM_CHAN];
	logic [CNT_W-1:0]    count_q  [NUM_CHAN];
	logic [NUM_CHAN-1:0] phase_q;
	logic [7:0]          ctrl_q;
	logic                out_valid_q;
	levels_t             out_q;

	logic [1:0]          in_addr;
	logic [7:0]          in_wdata;
	logic [TICK_W-1:0]   in_ticks;
	logic [TICK_W-1:0]   ticks_lim;
	logic [PER_W-1:0]    new_per;
	logic                in_acc;
	logic                out_free;
	logic [NUM_CHAN-1:0] chan_bit;
	div_req_t            div_req;
	div_rsp_t            div_rsp;
	levels_t             mix_levels;

	assign in_addr  = s_tdata[1:0];
	assign in_wdata = s_tdata[9:2];
	assign in_ticks = s_tdata[17:10];
	assign ticks_lim = (32'(in_ticks) > MAX_TICKS) ? TICK_W'(MAX_TICKS) : in_ticks;
	assign new_per  = ~in_wdata[PER_W-1:0];

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		div_req.start    = (state_q == ST_CHAN) && (period_q[ch_q] != '0);
		div_req.rem_init = ACC_W'(count_q[ch_q]) + ACC_W'(ticks_q);
		div_req.per      = period_q[ch_q];
	end

	tsg_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		for (int i = 0; i < NUM_CHAN; i++) begin
			chan_bit[i] = (period_q[i] != '0) && phase_q[i];
		end
	end

	tsg_mixer u_mix (
		.chan_bit (chan_bit),
		.ctrl     (ctrl_q),
		.levels   (mix_levels)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ch_q        <= '0;
			ticks_q     <= '0;
			phase_q     <= '0;
			ctrl_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_CHAN; i++) begin
				period_q[i] <= '0;
				count_q[i]  <= '0;
			end
		end else begin
			if (out_valid_q && m_tready && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (s_tuser == CMD_WRITE) begin
							if (in_addr == ADDR_CTRL) begin
								ctrl_q <= in_wdata;
							end else begin
								if (new_per == '0 && period_q[in_addr] != '0) begin
									phase_q[in_addr] <= ~phase_q[in_addr];
								end
								period_q[in_addr] <= new_per;
							end
						end else if (ctrl_q[CTRL_EN_BIT]) begin
							ticks_q <= ticks_lim;
							ch_q    <= '0;
							state_q <= ST_CHAN;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_CHAN: begin
					if (period_q[ch_q] != '0) begin
						state_q <= ST_DIV;
					end else if (ch_q == 2'(NUM_CHAN-1)) begin
						state_q <= ST_OUT;
					end else begin
						ch_q <= ch_q + 2'd1;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						count_q[ch_q] <= div_rsp.rem[CNT_W-1:0];
						phase_q[ch_q] <= phase_q[ch_q] ^ div_rsp.par;
						if (ch_q == 2'(NUM_CHAN-1)) begin
							state_q <= ST_OUT;
						end else begin
							ch_q    <= ch_q + 2'd1;
							state_q <= ST_CHAN;
						end
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			out_q <= mix_levels;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, out_q.level_c, out_q.level_b, out_q.level_a, out_q.sample};

endmodule

[hdl/tsg_divider.sv]
// Shared subtract unit of the tone generator.
// Subtracts a period repeatedly, one step a cycle, tracking quotient parity.
// Depends on tsg_pkg.
module tsg_divider
	import tsg_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic             busy_q;
	logic [ACC_W-1:0] rem_q;
	logic [PER_W-1:0] per_q;
	logic             par_q;
	logic             below;

	assign below = rem_q < {{(ACC_W-PER_W){1'b0}}, per_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
		end else if (busy_q && below) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem_init;
			per_q <= req.per;
			par_q <= 1'b0;
		end else if (busy_q && !below) begin
			rem_q <= rem_q - {{(ACC_W-PER_W){1'b0}}, per_q};
			par_q <= ~par_q;
		end
	end

	assign rsp.done = busy_q && below;
	assign rsp.rem  = rem_q;
	assign rsp.par  = par_q;

endmodule

[hdl/tsg_mixer.sv]
// Level mixer of the tone generator.
// Turns channel bits and the control byte into signed levels and their sum.
// Depends on tsg_pkg.
module tsg_mixer
	import tsg_pkg::*;
(
	input  logic [NUM_CHAN-1:0] chan_bit,
	input  logic [7:0]          ctrl,
	output levels_t             levels
);

	logic [NUM_CHAN-1:0]       pos;
	logic signed [LVL_A_W-1:0] lv_a;
	logic signed [LVL_B_W-1:0] lv_b;
	logic signed [LVL_C_W-1:0] lv_c;

	always_comb begin
		if (ctrl[CTRL_MIX_BIT]) begin
			pos[0] = chan_bit[0] ^ chan_bit[1];
			pos[1] = chan_bit[1] ^ chan_bit[2];
			pos[2] = chan_bit[2];
		end else begin
			pos = chan_bit;
		end
		if (ctrl[CTRL_EN_BIT]) begin
			lv_a = pos[0] ? LVL_A_W'(VOL_A) : LVL_A_W'(-VOL_A);
			lv_b = pos[1] ? LVL_B_W'(VOL_B) : LVL_B_W'(-VOL_B);
			lv_c = pos[2] ? LVL_C_W'(VOL_C) : LVL_C_W'(-VOL_C);
		end else begin
			lv_a = '0;
			lv_b = '0;
			lv_c = '0;
		end
		levels.level_a = lv_a;
		levels.level_b = lv_b;
		levels.level_c = lv_c;
		levels.sample  = SAMPLE_W'(lv_a) + SAMPLE_W'(lv_b) + SAMPLE_W'(lv_c);
	end

endmodule

[test/tb.sv]
// Testbench for the three-channel square tone generator.
// Drives register writes and tick transactions and checks every sample
// against an internal prediction. Depends on tsg_pkg and the generator RTL.
`timescale 1ns / 1ps

module tb;
	import tsg_pkg::*;

	localparam int unsigned TB_MAX_TICKS = MAX_TICKS_DEF;
	localparam longint unsigned LIMIT_CYCLES = 10_000_000;
	localparam int DRAIN_CYCLES = 1000;
	localparam int RANDOM_ITEMS = 1800;

	typedef struct {
		logic       cmd;
		logic [1:0] addr;
		logic [7:0] wdata;
		logic [7:0] ticks;
		bit         wait_idle;
	} tone_item_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	tone_item_t stim_q[$];
	levels_t    tone_expect_q[$];
	tone_item_t drv_item;

	logic [PER_W-1:0] shadow_period [NUM_CHAN];
	logic [CNT_W-1:0] shadow_count [NUM_CHAN];
	logic             shadow_phase [NUM_CHAN];
	logic [7:0]       shadow_ctrl;

	int              fail_count = 0;
	int              accepted_items = 0;
	int              total_items = 0;
	int              send_gap = 0;
	int              stall_left = 0;
	bit              no_idle = 1'b0;
	longint unsigned cycle_count = 0;

	three_square_tone_generator #(
		.MAX_TICKS(TB_MAX_TICKS)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #5 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH: %s", msg);
		fail_count++;
	endtask

	task automatic queue_write(input logic [1:0] addr, input logic [7:0] wdata);
		tone_item_t it;
		it.cmd = CMD_WRITE;
		it.addr = addr;
		it.wdata = wdata;
		it.ticks = 8'($urandom_range(0, 255));
		it.wait_idle = 1'b0;
		stim_q.push_back(it);
	endtask

	task automatic queue_tick(input logic [7:0] ticks);
		tone_item_t it;
		it.cmd = CMD_TICK;
		it.addr = 2'($urandom_range(0, 3));
		it.wdata = 8'($urandom_range(0, 255));
		it.ticks = ticks;
		it.wait_idle = 1'b0;
		stim_q.push_back(it);
	endtask

	task automatic predict_levels(input tone_item_t it);
		levels_t          r;
		logic [PER_W-1:0] per;
		int unsigned      eff_ticks;
		int unsigned      total;
		logic [2:0]       bits;
		logic [2:0]       pos;
		int               lv [NUM_CHAN];
		if (it.cmd == CMD_WRITE) begin
			if (it.addr == ADDR_CTRL) begin
				shadow_ctrl = it.wdata;
			end else begin
				per = ~it.wdata[PER_W-1:0];
				if (per == 0 && shadow_period[it.addr] != 0)
					shadow_phase[it.addr] = ~shadow_phase[it.addr];
				shadow_period[it.addr] = per;
			end
		end else begin
			eff_ticks = (it.ticks > TB_MAX_TICKS) ? TB_MAX_TICKS : it.ticks;
			r = '0;
			if (shadow_ctrl[CTRL_EN_BIT]) begin
				for (int ch = 0; ch < NUM_CHAN; ch++) begin
					if (shadow_period[ch] == 0) begin
						bits[ch] = 1'b0;
					end else begin
						total = shadow_count[ch] + eff_ticks;
						shadow_phase[ch] = shadow_phase[ch] ^
							1'((total / shadow_period[ch]) & 1);
						shadow_count[ch] = CNT_W'(total % shadow_period[ch]);
						bits[ch] = shadow_phase[ch];
					end
				end
				if (shadow_ctrl[CTRL_MIX_BIT])
					pos = {bits[2], bits[1] ^ bits[2], bits[0] ^ bits[1]};
				else
					pos = bits;
				lv[0] = pos[0] ? VOL_A : -VOL_A;
				lv[1] = pos[1] ? VOL_B : -VOL_B;
				lv[2] = pos[2] ? VOL_C : -VOL_C;
				r.level_a = LVL_A_W'(lv[0]);
				r.level_b = LVL_B_W'(lv[1]);
				r.level_c = LVL_C_W'(lv[2]);
				r.sample = SAMPLE_W'(lv[0] + lv[1] + lv[2]);
			end
			tone_expect_q.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : drive
		bit accepted;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
		end else begin
			accepted = s_tvalid && s_tready;
			if (accepted) begin
				predict_levels(drv_item);
				accepted_items++;
				if ($urandom_range(0, 79) == 0) no_idle = ~no_idle;
				send_gap = pick_gap();
			end
			if (!s_tvalid || accepted) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (stim_q.size() > 0 &&
						!(stim_q[0].wait_idle && tone_expect_q.size() != 0)) begin
					drv_item = stim_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {{(IN_DATA_W-18){1'b0}}, drv_item.ticks, drv_item.wdata,
						drv_item.addr};
					s_tuser <= drv_item.cmd;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : watch
		levels_t got;
		levels_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.sample = m_tdata[15:0];
				got.level_a = m_tdata[28:16];
				got.level_b = m_tdata[42:29];
				got.level_c = m_tdata[57:43];
				if (tone_expect_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result sample %0d", got.sample));
				end else begin
					want = tone_expect_q.pop_front();
					if (got.sample !== want.sample)
						report_mismatch($sformatf("sample expected %0d got %0d",
							want.sample, got.sample));
					if (got.level_a !== want.level_a)
						report_mismatch($sformatf("level_a expected %0d got %0d",
							want.level_a, got.level_a));
					if (got.level_b !== want.level_b)
						report_mismatch($sformatf("level_b expected %0d got %0d",
							want.level_b, got.level_b));
					if (got.level_c !== want.level_c)
						report_mismatch($sformatf("level_c expected %0d got %0d",
							want.level_c, got.level_c));
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 5) == 0) stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles.", cycle_count);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin : stimulus
		logic [7:0] data;
		int         kind;
		for (int ch = 0; ch < NUM_CHAN; ch++) begin
			shadow_period[ch] = '0;
			shadow_count[ch] = '0;
			shadow_phase[ch] = 1'b0;
		end
		shadow_ctrl = '0;

		queue_tick(8'd0);
		queue_write(ADDR_CTRL, 8'h02);
		queue_tick(8'd255);
		queue_write(2'd0, 8'h00);
		queue_write(2'd1, 8'hFE);
		queue_write(2'd2, 8'hF0);
		queue_tick(8'd0);
		queue_tick(8'd255);
		queue_tick(8'd1);
		queue_write(ADDR_CTRL, 8'h03);
		queue_tick(8'd100);
		queue_tick(8'd7);
		queue_write(2'd1, 8'hFF);
		queue_tick(8'd3);
		queue_write(2'd0, 8'hFD);
		queue_tick(8'd5);
		queue_write(ADDR_CTRL, 8'hFD);
		queue_tick(8'd50);
		queue_write(ADDR_CTRL, 8'hFF);
		queue_tick(8'd200);
		queue_write(2'd2, 8'h3F);
		queue_tick(8'd9);
		queue_write(2'd1, 8'h80);
		queue_tick(8'hAA);
		stim_q[stim_q.size()-1].wait_idle = 1'b1;

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			kind = $urandom_range(0, 99);
			if (kind < 9) begin
				data = 8'($urandom_range(0, 255));
				if ($urandom_range(0, 9) < 8) data[CTRL_EN_BIT] = 1'b1;
				queue_write(ADDR_CTRL, data);
			end else if (kind < 33) begin
				data = 8'($urandom_range(0, 255));
				if ($urandom_range(0, 7) == 0) data[PER_W-1:0] = '1;
				queue_write(2'($urandom_range(0, 2)), data);
			end else begin
				kind = $urandom_range(0, 9);
				if (kind == 0) queue_tick(8'd0);
				else if (kind == 1) queue_tick(8'd255);
				else queue_tick(8'($urandom_range(0, 255)));
			end
			if (n == RANDOM_ITEMS / 2) stim_q[stim_q.size()-1].wait_idle = 1'b1;
		end
		total_items = stim_q.size();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_items < total_items || tone_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
